// File: rtl/sct_pkg.sv
// shared codes and widths for the counting semaphore table
`default_nettype none

package sct_pkg;

   typedef logic [1:0] action_type;
   typedef logic [1:0] status_type;

   localparam action_type ACT_CREATE = 2'd0;
   localparam action_type ACT_DOWN   = 2'd1;
   localparam action_type ACT_UP     = 2'd2;
   localparam action_type ACT_CLOSE  = 2'd3;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_INVALID = 2'd1;
   localparam status_type ST_FULL    = 2'd2;

   localparam int ID_W   = 32;
   localparam int CNT_W  = 32;
   localparam int TASK_W = 16;

   localparam logic [CNT_W-1:0] CNT_MIN = 32'h8000_0000;
   localparam logic [CNT_W-1:0] CNT_MAX = 32'h7fff_ffff;

endpackage

`default_nettype wire

// File: rtl/sct_ram.sv
// generic single write port ram with registered read
`default_nettype none

module sct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/counting_semaphore_table.sv
// counting semaphore table with per-slot fifo wait queues
//
// Each request produces exactly one response item. Ids are located by a scan that
// reads the slot record memory one slot per cycle through its single read port and
// checks it with one shared compare unit, so an item that hits slot k first scans
// slots 0 to k (an up that wakes a waiter then also reads the wait memory), and a
// miss scans every slot. A create with a negative start value skips the scan and
// goes straight to the done state. One item is worked on at a time; a new item is
// taken while the previous response still waits.
`default_nettype none

module counting_semaphore_table
   import sct_pkg::*;
#(
   parameter int NUM_SLOTS   = 16,
   parameter int QUEUE_DEPTH = 8,
   parameter int TASK_BITS   = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_action,
   input  wire logic signed [31:0] req_start_value,
   input  wire logic [31:0]       req_target_id,
   input  wire logic [15:0]       req_task_id,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_new_id,
   output logic                   rsp_blocked,
   output logic                   rsp_woken_valid,
   output logic [15:0]            rsp_woken_task
);

   localparam int SB     = $clog2(NUM_SLOTS);
   localparam int QB     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FB     = $clog2(QUEUE_DEPTH + 1);
   localparam int PW     = FB + 1;
   localparam int WDEPTH = NUM_SLOTS * QUEUE_DEPTH;
   localparam int WAB    = $clog2(WDEPTH);
   localparam int RW     = ID_W + CNT_W + QB + FB;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_WAKE = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]           state_ff, state_in;
   action_type           act_ff, act_in;
   logic [CNT_W-1:0]     start_ff, start_in;
   logic [ID_W-1:0]      target_ff, target_in;
   logic [TASK_BITS-1:0] task_ff, task_in;
   logic [SB-1:0]        issue_ff, issue_in;
   logic [SB-1:0]        chk_ff, chk_in;
   logic                 pend_ff, pend_in;
   logic [SB-1:0]        slot_ff, slot_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [QB-1:0]        head_ff, head_in;
   logic [FB-1:0]        fill_ff, fill_in;
   logic [NUM_SLOTS-1:0] in_use_ff, in_use_in;
   logic [ID_W-1:0]      next_ident_ff, next_ident_in;

   status_type           res_status_ff, res_status_in;
   logic [ID_W-1:0]      res_new_id_ff, res_new_id_in;
   logic                 res_blocked_ff, res_blocked_in;
   logic                 res_wvalid_ff, res_wvalid_in;
   logic [TASK_W-1:0]    res_wtask_ff, res_wtask_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]      rsp_new_id_ff, rsp_new_id_in;
   logic                 rsp_blocked_ff, rsp_blocked_in;
   logic                 rsp_wvalid_ff, rsp_wvalid_in;
   logic [TASK_W-1:0]    rsp_wtask_ff, rsp_wtask_in;

   logic                 rec_wr_en;
   logic [RW-1:0]        rec_wr_data;
   logic [RW-1:0]        rec_rd_data;
   logic [ID_W-1:0]      rd_ident;
   logic [CNT_W-1:0]     rd_count;
   logic [QB-1:0]        rd_head;
   logic [FB-1:0]        rd_fill;

   logic                 wt_wr_en;
   logic [WAB-1:0]       wt_addr;
   logic [TASK_BITS-1:0] wt_rd_data;

   logic                 accept;
   logic                 hit;
   logic                 at_last;
   logic [TASK_BITS+15:0] task_ext;
   logic [TASK_BITS+15:0] wake_ext;
   logic [PW-1:0]        tail_sum;
   logic [PW-1:0]        tail_pos;
   logic [PW-1:0]        head_inc;
   logic [QB-1:0]        qpos;
   logic [CNT_W-1:0]     cnt_dec;
   logic [CNT_W-1:0]     cnt_inc;

   sct_ram #(
      .WIDTH (RW),
      .DEPTH (NUM_SLOTS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (slot_ff),
      .wr_data (rec_wr_data),
      .rd_addr (issue_ff),
      .rd_data (rec_rd_data)
   );

   sct_ram #(
      .WIDTH (TASK_BITS),
      .DEPTH (WDEPTH)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (wt_wr_en),
      .wr_addr (wt_addr),
      .wr_data (task_ff),
      .rd_addr (wt_addr),
      .rd_data (wt_rd_data)
   );

   assign rd_ident = rec_rd_data[RW-1 -: ID_W];
   assign rd_count = rec_rd_data[RW-ID_W-1 -: CNT_W];
   assign rd_head  = rec_rd_data[FB +: QB];
   assign rd_fill  = rec_rd_data[FB-1:0];

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign task_ext = {{TASK_BITS{1'b0}}, req_task_id};
   assign wake_ext = {16'h0000, wt_rd_data};

   assign at_last = (chk_ff == SB'(NUM_SLOTS - 1));
   assign hit = pend_ff && ((act_ff == ACT_CREATE) ? !in_use_ff[chk_ff]
                            : (in_use_ff[chk_ff] && (rd_ident == target_ff)));

   // queue position: tail for down, head for up
   assign tail_sum = PW'(head_ff) + PW'(fill_ff);
   assign tail_pos = (tail_sum >= PW'(QUEUE_DEPTH)) ? tail_sum - PW'(QUEUE_DEPTH) : tail_sum;
   assign head_inc = (PW'(head_ff) + PW'(1) == PW'(QUEUE_DEPTH)) ? '0 : PW'(head_ff) + PW'(1);
   assign qpos     = (act_ff == ACT_DOWN) ? tail_pos[QB-1:0] : head_ff;
   assign wt_addr  = WAB'(slot_ff) * WAB'(QUEUE_DEPTH) + WAB'(qpos);

   assign cnt_dec = cnt_ff - 32'd1;
   assign cnt_inc = cnt_ff + 32'd1;

   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      start_in       = start_ff;
      target_in      = target_ff;
      task_in        = task_ff;
      issue_in       = issue_ff;
      chk_in         = chk_ff;
      pend_in        = pend_ff;
      slot_in        = slot_ff;
      cnt_in         = cnt_ff;
      head_in        = head_ff;
      fill_in        = fill_ff;
      in_use_in      = in_use_ff;
      next_ident_in  = next_ident_ff;
      res_status_in  = res_status_ff;
      res_new_id_in  = res_new_id_ff;
      res_blocked_in = res_blocked_ff;
      res_wvalid_in  = res_wvalid_ff;
      res_wtask_in   = res_wtask_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_new_id_in  = rsp_new_id_ff;
      rsp_blocked_in = rsp_blocked_ff;
      rsp_wvalid_in  = rsp_wvalid_ff;
      rsp_wtask_in   = rsp_wtask_ff;
      rec_wr_en      = 1'b0;
      rec_wr_data    = {target_ff, cnt_ff, head_ff, fill_ff};
      wt_wr_en       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in         = req_action;
               start_in       = req_start_value;
               target_in      = req_target_id;
               task_in        = task_ext[TASK_BITS-1:0];
               issue_in       = '0;
               pend_in        = 1'b0;
               res_status_in  = ST_OK;
               res_new_id_in  = '0;
               res_blocked_in = 1'b0;
               res_wvalid_in  = 1'b0;
               res_wtask_in   = '0;
               if (req_action == ACT_CREATE && req_start_value[31]) begin
                  res_status_in = ST_INVALID;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               slot_in  = chk_ff;
               cnt_in   = rd_count;
               head_in  = rd_head;
               fill_in  = rd_fill;
               state_in = S_EXEC;
            end else if (pend_ff && at_last) begin
               res_status_in = (act_ff == ACT_CREATE) ? ST_FULL : ST_INVALID;
               state_in      = S_DONE;
            end else begin
               chk_in   = issue_ff;
               pend_in  = 1'b1;
               issue_in = issue_ff + SB'(1);
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            unique case (act_ff)
               ACT_CREATE: begin
                  rec_wr_en         = 1'b1;
                  rec_wr_data       = {next_ident_ff, start_ff, QB'(0), FB'(0)};
                  in_use_in[slot_ff] = 1'b1;
                  res_new_id_in     = next_ident_ff;
                  next_ident_in     = next_ident_ff + 32'd1;
               end
               ACT_DOWN: begin
                  if (cnt_ff == CNT_MIN) begin
                     res_status_in = ST_INVALID;
                  end else if (cnt_dec[31]) begin
                     if (fill_ff >= FB'(QUEUE_DEPTH)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        wt_wr_en       = 1'b1;
                        rec_wr_en      = 1'b1;
                        rec_wr_data    = {target_ff, cnt_dec, head_ff, fill_ff + FB'(1)};
                        res_blocked_in = 1'b1;
                     end
                  end else begin
                     rec_wr_en   = 1'b1;
                     rec_wr_data = {target_ff, cnt_dec, head_ff, fill_ff};
                  end
               end
               ACT_UP: begin
                  if (cnt_ff == CNT_MAX) begin
                     res_status_in = ST_INVALID;
                  end else begin
                     rec_wr_en   = 1'b1;
                     rec_wr_data = {target_ff, cnt_inc, head_ff, fill_ff};
                     if ((cnt_inc[31] || cnt_inc == '0) && fill_ff != '0) begin
                        rec_wr_data = {target_ff, cnt_inc, head_inc[QB-1:0],
                                       fill_ff - FB'(1)};
                        state_in    = S_WAKE;
                     end
                  end
               end
               ACT_CLOSE: begin
                  if (fill_ff != '0) begin
                     res_status_in = ST_INVALID;
                  end else begin
                     in_use_in[slot_ff] = 1'b0;
                  end
               end
               default: begin
                  res_status_in = ST_INVALID;
               end
            endcase
         end
         S_WAKE: begin
            res_wvalid_in = 1'b1;
            res_wtask_in  = wake_ext[15:0];
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_new_id_in  = res_new_id_ff;
               rsp_blocked_in = res_blocked_ff;
               rsp_wvalid_in  = res_wvalid_ff;
               rsp_wtask_in   = res_wtask_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_ff       <= 1'b0;
         in_use_ff     <= '0;
         next_ident_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         in_use_ff     <= in_use_in;
         next_ident_ff <= next_ident_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      start_ff       <= start_in;
      target_ff      <= target_in;
      task_ff        <= task_in;
      issue_ff       <= issue_in;
      chk_ff         <= chk_in;
      slot_ff        <= slot_in;
      cnt_ff         <= cnt_in;
      head_ff        <= head_in;
      fill_ff        <= fill_in;
      res_status_ff  <= res_status_in;
      res_new_id_ff  <= res_new_id_in;
      res_blocked_ff <= res_blocked_in;
      res_wvalid_ff  <= res_wvalid_in;
      res_wtask_ff   <= res_wtask_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_new_id_ff  <= rsp_new_id_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_wvalid_ff  <= rsp_wvalid_in;
      rsp_wtask_ff   <= rsp_wtask_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_new_id      = rsp_new_id_ff;
   assign rsp_blocked     = rsp_blocked_ff;
   assign rsp_woken_valid = rsp_wvalid_ff;
   assign rsp_woken_task  = rsp_wtask_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the done state");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_SCAN || state_ff == S_DONE))
      else $error("accepted item did not start work");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_blocked_ff && rsp_wvalid_ff))
      else $error("item both blocked and woke a task");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |->
         (rsp_new_id_ff == '0 && !rsp_blocked_ff && !rsp_wvalid_ff))
      else $error("failed item carries result data");

endmodule

`default_nettype wire

// File: dv/counting_semaphore_table_tb.sv
// self-checking testbench for the counting semaphore table
`timescale 1ns / 100ps

module counting_semaphore_table_tb
   import sct_pkg::*;
();

   localparam int SLOTS          = 16;
   localparam int QDEPTH         = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = SLOTS + 10;
   localparam int LONG_HOLD      = 150;

   typedef struct packed {
      status_type  status;
      logic [31:0] new_id;
      logic        blocked;
      logic        woken_valid;
      logic [15:0] woken_task;
   } sem_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   action_type  req_action = ACT_CREATE;
   logic signed [31:0] req_start_value = '0;
   logic [31:0] req_target_id = '0;
   logic [15:0] req_task_id = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_new_id;
   logic        rsp_blocked;
   logic        rsp_woken_valid;
   logic [15:0] rsp_woken_task;

   // semaphore table as the testbench tracks it
   bit          sem_busy [SLOTS];
   bit [31:0]   sem_ident [SLOTS];
   bit [31:0]   sem_count [SLOTS];
   bit [15:0]   sem_waiters [SLOTS][QDEPTH];
   int          sem_head [SLOTS];
   int          sem_fill [SLOTS];
   bit [31:0]   sem_next_id;
   status_type  last_status;
   bit [31:0]   last_new_id;

   sem_result_type sem_expected[$];

   int fail_count;
   int items_sent;
   int results_checked;
   int n_created, n_table_full, n_queue_full, n_blocked, n_woken, n_invalid;
   bit send_gaps_on = 1'b1;
   bit stall_bursts_on = 1'b1;
   int hold_asked;
   int hold_taken;
   int stall_left;
   int quiet_cycles;

   always #5 clock = ~clock;

   counting_semaphore_table #(
      .NUM_SLOTS   (SLOTS),
      .QUEUE_DEPTH (QDEPTH),
      .TASK_BITS   (16)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_start_value (req_start_value),
      .req_target_id   (req_target_id),
      .req_task_id     (req_task_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_new_id      (rsp_new_id),
      .rsp_blocked     (rsp_blocked),
      .rsp_woken_valid (rsp_woken_valid),
      .rsp_woken_task  (rsp_woken_task)
   );

   function automatic sem_result_type predict_sem(action_type act, logic signed [31:0] start,
                                                  logic [31:0] target, logic [15:0] task_id);
      sem_result_type r;
      int slot;
      int pos;
      logic [31:0] cnt;
      logic [31:0] nxt;
      r = '0;
      r.status = ST_OK;
      slot = -1;
      if (act == ACT_CREATE) begin
         if (start < 0) begin
            r.status = ST_INVALID;
         end else begin
            for (int i = SLOTS - 1; i >= 0; i--)
               if (!sem_busy[i]) slot = i;
            if (slot < 0) begin
               r.status = ST_FULL;
               n_table_full++;
            end else begin
               sem_busy[slot] = 1'b1;
               sem_count[slot] = start;
               sem_ident[slot] = sem_next_id;
               sem_head[slot] = 0;
               sem_fill[slot] = 0;
               r.new_id = sem_next_id;
               sem_next_id = sem_next_id + 32'd1;
               n_created++;
            end
         end
      end else begin
         // lowest matching slot wins
         for (int i = SLOTS - 1; i >= 0; i--)
            if (sem_busy[i] && sem_ident[i] == target) slot = i;
         if (slot < 0) begin
            r.status = ST_INVALID;
         end else begin
            cnt = sem_count[slot];
            case (act)
               ACT_DOWN: begin
                  nxt = cnt - 32'd1;
                  if (cnt == CNT_MIN) begin
                     r.status = ST_INVALID;
                  end else if (!nxt[31]) begin
                     sem_count[slot] = nxt;
                  end else if (sem_fill[slot] >= QDEPTH) begin
                     r.status = ST_FULL;
                     n_queue_full++;
                  end else begin
                     pos = (sem_head[slot] + sem_fill[slot]) % QDEPTH;
                     sem_waiters[slot][pos] = task_id;
                     sem_fill[slot]++;
                     sem_count[slot] = nxt;
                     r.blocked = 1'b1;
                     n_blocked++;
                  end
               end
               ACT_UP: begin
                  nxt = cnt + 32'd1;
                  if (cnt == CNT_MAX) begin
                     r.status = ST_INVALID;
                  end else begin
                     sem_count[slot] = nxt;
                     if ((nxt[31] || nxt == 32'd0) && sem_fill[slot] > 0) begin
                        pos = sem_head[slot];
                        r.woken_valid = 1'b1;
                        r.woken_task = sem_waiters[slot][pos];
                        sem_head[slot] = (pos + 1) % QDEPTH;
                        sem_fill[slot]--;
                        n_woken++;
                     end
                  end
               end
               default: begin
                  if (sem_fill[slot] != 0) begin
                     r.status = ST_INVALID;
                  end else begin
                     sem_busy[slot] = 1'b0;
                     sem_head[slot] = 0;
                  end
               end
            endcase
         end
      end
      if (r.status == ST_INVALID) n_invalid++;
      last_status = r.status;
      last_new_id = r.new_id;
      return r;
   endfunction

   function automatic logic [31:0] pick_live_id();
      int live[$];
      for (int i = 0; i < SLOTS; i++)
         if (sem_busy[i]) live.push_back(i);
      if (live.size() == 0) return $urandom;
      return sem_ident[live[$urandom_range(0, live.size() - 1)]];
   endfunction

   function automatic logic signed [31:0] random_start();
      case ($urandom_range(0, 9))
         6: return $urandom;
         7: return CNT_MAX - $urandom_range(0, 2);
         8: return -$urandom_range(1, 4);
         9: return 32'h8000_0000 | $urandom;
         default: return $urandom_range(0, 3);
      endcase
   endfunction

   function automatic logic [31:0] random_target();
      case ($urandom_range(0, 9))
         7: return sem_next_id - 32'($urandom_range(1, 4));
         8, 9: return $urandom;
         default: return pick_live_id();
      endcase
   endfunction

   task automatic send_item(action_type act, logic signed [31:0] start,
                            logic [31:0] target, logic [15:0] task_id);
      if (send_gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_start_value <= start;
      req_target_id <= target;
      req_task_id <= task_id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sem_expected.push_back(predict_sem(act, start, target, task_id));
      items_sent++;
   endtask

   task automatic send_random(int n, int w_create, int w_down, int w_up, int w_close,
                              bit focus);
      logic [31:0] focus_id;
      int roll;
      action_type act;
      focus_id = pick_live_id();
      for (int k = 0; k < n; k++) begin
         roll = $urandom_range(0, w_create + w_down + w_up + w_close - 1);
         if (roll < w_create) act = ACT_CREATE;
         else if (roll < w_create + w_down) act = ACT_DOWN;
         else if (roll < w_create + w_down + w_up) act = ACT_UP;
         else act = ACT_CLOSE;
         send_item(act, random_start(),
                   (focus && $urandom_range(0, 3) != 0) ? focus_id : random_target(),
                   16'($urandom));
      end
   endtask

   task automatic test_directed();
      logic [31:0] id_a, id_b;
      // unknown ids on an empty table
      send_item(ACT_DOWN, 0, 32'd0, 16'h0001);
      send_item(ACT_UP, 0, 32'hffff_ffff, 16'h0000);
      send_item(ACT_CLOSE, 0, 32'h8000_0000, 16'h0000);
      // negative start values, then valid creates at zero and at the top count
      send_item(ACT_CREATE, 32'sh8000_0000, 32'd0, 16'h0000);
      send_item(ACT_CREATE, -1, 32'd0, 16'h0000);
      id_a = sem_next_id;
      send_item(ACT_CREATE, 0, 32'hffff_ffff, 16'hffff);
      id_b = sem_next_id;
      send_item(ACT_CREATE, 32'sh7fff_ffff, 32'd0, 16'h0000);
      // count overflow on up, then downs (two of them block on id_a)
      send_item(ACT_UP, 0, id_b, 16'h0000);
      send_item(ACT_DOWN, 0, id_b, 16'hffff);
      send_item(ACT_DOWN, 0, id_a, 16'hffff);
      send_item(ACT_DOWN, 0, id_a, 16'h0000);
      // close with waiters, then wakeups and a close once the queue is empty
      send_item(ACT_CLOSE, 0, id_a, 16'h0000);
      send_item(ACT_UP, 0, id_a, 16'h0000);
      send_item(ACT_UP, 0, id_a, 16'h0000);
      send_item(ACT_UP, 0, id_a, 16'h0000);
      send_item(ACT_DOWN, 0, id_a, 16'h5a5a);
      send_item(ACT_CLOSE, 0, id_a, 16'h0000);
      // stale id after close
      send_item(ACT_DOWN, 0, id_a, 16'h0000);
      send_item(ACT_CLOSE, 0, id_b, 16'h0000);
      send_item(ACT_CREATE, 1, 32'd0, 16'h0000);
   endtask

   task automatic test_queue_depth(int rounds);
      logic [31:0] id;
      for (int r = 0; r < rounds; r++) begin
         send_item(ACT_CREATE, $urandom_range(0, 2), $urandom, 16'($urandom));
         id = (last_status == ST_OK) ? last_new_id : pick_live_id();
         repeat (QDEPTH + 4) send_item(ACT_DOWN, random_start(), id, 16'($urandom));
         send_item(ACT_CLOSE, random_start(), id, 16'($urandom));
         // walk the ring around
         repeat (6) begin
            send_item(ACT_UP, random_start(), id, 16'($urandom));
            send_item(ACT_DOWN, random_start(), id, 16'($urandom));
         end
         repeat (QDEPTH + 4) send_item(ACT_UP, random_start(), id, 16'($urandom));
         send_item(ACT_CLOSE, random_start(), id, 16'($urandom));
      end
   endtask

   task automatic test_table_full();
      repeat (SLOTS + 3) send_item(ACT_CREATE, $urandom_range(0, 5), $urandom, 16'($urandom));
   endtask

   task automatic test_random_mix(int chunks);
      for (int c = 0; c < chunks; c++)
         send_random(50, 25, 35, 25, 15, c[0]);
   endtask

   task automatic test_backpressure();
      hold_asked++;
      send_random(8, 25, 35, 25, 15, 1'b0);
   endtask

   task automatic test_drain();
      send_random(150, 5, 15, 45, 35, 1'b0);
   endtask

   task automatic test_no_idle();
      send_gaps_on = 1'b0;
      stall_bursts_on = 1'b0;
      send_random(250, 25, 35, 25, 15, 1'b1);
   endtask

   // receiver: random stall bursts plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (hold_asked != hold_taken) begin
         rsp_stall <= 1'b1;
         stall_left <= LONG_HOLD - 1;
         hold_taken <= hold_asked;
      end else if (stall_bursts_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t mismatch %s: expected %0h actual %0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_results
      sem_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (sem_expected.size() == 0) begin
            fail_count++;
            $display("%0t unexpected item: expected none actual status %0h",
                     $time, rsp_status);
         end else begin
            want = sem_expected.pop_front();
            compare_field("status", want.status, rsp_status);
            compare_field("new_id", want.new_id, rsp_new_id);
            compare_field("blocked", want.blocked, rsp_blocked);
            compare_field("woken_valid", want.woken_valid, rsp_woken_valid);
            compare_field("woken_task", want.woken_task, rsp_woken_task);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no handshake in %0d cycles", $time, WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_queue_depth(4);
      test_table_full();
      test_random_mix(10);
      test_backpressure();
      test_drain();
      test_random_mix(6);
      test_no_idle();
      req_valid <= 1'b0;
      while (sem_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run: %0d items, %0d results checked, %0d creates, %0d table-full refusals",
               items_sent, results_checked, n_created, n_table_full);
      $display("run: %0d blocked downs, %0d wakeups, %0d queue-full, %0d invalid answers",
               n_blocked, n_woken, n_queue_full, n_invalid);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
